// ===== rtl/sleg_pkg.sv =====
package sleg_pkg;

    localparam int BREATH_PERIOD_MS_DEF = 2000;
    localparam int BLINK_HALF_MS_DEF    = 166;

    localparam int LEVEL_W    = 8;
    localparam int DUTY_W     = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;
    localparam int DBITS_W    = 5;
    localparam int BRIGHT_W   = 9;

    // Shared multiplier operand and product widths
    localparam int MUL_W  = 26;
    localparam int PROD_W = 2 * MUL_W;

    localparam logic [DBITS_W-1:0]  DUTY_BITS_RST  = 5'd8;
    localparam logic [BRIGHT_W-1:0] BRIGHTNESS_RST = 9'd256;

    localparam logic [LEVEL_W-1:0] LVL_CONNECTED = 8'd200;
    localparam logic [LEVEL_W-1:0] LVL_SENDING   = 8'd180;
    localparam logic [LEVEL_W-1:0] LVL_ARMING    = 8'd200;
    localparam logic [LEVEL_W-1:0] LVL_RED       = 8'd140;

    // ceil(2^33 / 255): exact floor division by 255 for values below 2^25
    localparam logic [MUL_W-1:0] RECIP_255   = 26'd33686019;
    localparam int               RECIP_SHIFT = 33;

    localparam logic [63:0] PI_Q62 = 64'hC90F_DAA2_2168_C235;

    typedef enum logic {
        OP_TICK     = 1'b0,
        OP_SET_MODE = 1'b1
    } t_opcode;

    typedef enum logic [2:0] {
        MODE_OFF         = 3'd0,
        MODE_CONNECTED   = 3'd1,
        MODE_SENDING     = 3'd2,
        MODE_ARMING      = 3'd3,
        MODE_ADVERTISING = 3'd4,
        MODE_RED         = 3'd5
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DUTY_BITS  = 2'd0,
        REG_BRIGHTNESS = 2'd1,
        REG_INVERT     = 2'd2
    } t_cfg_reg;

    // Long division by shift and subtract, used only to build constant tables
    function automatic logic [63:0] div_u64(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] rem;
        logic [63:0] quo;
        int          i;
        rem = '0;
        quo = '0;
        for (i = 63; i >= 0; i--) begin
            rem = {rem[63:0], a[i]};
            if (rem >= {1'b0, b}) begin
                rem    = rem - {1'b0, b};
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] prod;
        prod = {64'd0, a} * {64'd0, b};
        return prod[125:62];
    endfunction

    // floor(150 * sin^2(pi * k / p)) by Taylor series in Q62, k already folded
    function automatic logic [LEVEL_W-1:0] breath_level(input int unsigned k,
                                                        input int unsigned p);
        logic [63:0] quo;
        logic [63:0] rem;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] s2;
        logic [63:0] lvl;
        logic [63:0] dv;
        int          n;
        if (k == 0) return '0;
        if (2 * k == p) return 8'd150;
        if (4 * k == p) return 8'd75;
        quo  = div_u64(PI_Q62, 64'(p));
        rem  = PI_Q62 - quo * 64'(p);
        x    = quo * 64'(k) + div_u64(rem * 64'(k), 64'(p));
        x2   = mul_q62(x, x);
        term = x;
        sum  = x;
        for (n = 1; n < 16; n++) begin
            if (term != 0) begin
                dv   = 64'((2 * n) * (2 * n + 1));
                term = div_u64(mul_q62(term, x2), dv);
                if (n % 2 == 1) begin
                    sum = sum - term;
                end else begin
                    sum = sum + term;
                end
            end
        end
        s2  = mul_q62(sum, sum);
        lvl = mul_q62(s2, 64'd150);
        return (lvl > 64'd150) ? 8'd150 : lvl[LEVEL_W-1:0];
    endfunction

endpackage

// ===== rtl/sleg_item_if.sv =====
interface sleg_item_if;
    logic       valid;
    logic       ready;
    logic       opcode;
    logic [2:0] new_mode;

    modport source (output valid, output opcode, output new_mode, input ready);
    modport sink   (input valid, input opcode, input new_mode, output ready);
endinterface

// ===== rtl/sleg_result_if.sv =====
interface sleg_result_if;
    logic                        valid;
    logic                        ready;
    logic [sleg_pkg::DUTY_W-1:0] red_duty;
    logic [sleg_pkg::DUTY_W-1:0] green_duty;
    logic [sleg_pkg::DUTY_W-1:0] blue_duty;

    modport source (output valid, output red_duty, output green_duty, output blue_duty,
                    input ready);
    modport sink   (input valid, input red_duty, input green_duty, input blue_duty,
                    output ready);
endinterface

// ===== rtl/sleg_cfg_if.sv =====
interface sleg_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [sleg_pkg::CFG_IDX_W-1:0]  index;
    logic [sleg_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/sleg_breath_rom.sv =====
module sleg_breath_rom #(
    parameter int  PERIOD = sleg_pkg::BREATH_PERIOD_MS_DEF,
    localparam int DEPTH  = PERIOD / 2 + 1,
    localparam int AW     = $clog2(DEPTH)
) (
    input  logic                         i_clk,
    input  logic                         i_rd_en,
    input  logic [AW-1:0]                i_addr,
    output logic [sleg_pkg::LEVEL_W-1:0] o_level
);

    logic [sleg_pkg::LEVEL_W-1:0] w_rom [DEPTH];
    logic [sleg_pkg::LEVEL_W-1:0] r_level;

    // Half period of the sin^2 curve, indexed by folded phase
    for (genvar g = 0; g < DEPTH; g++) begin : g_rom
        localparam logic [sleg_pkg::LEVEL_W-1:0] LVL = sleg_pkg::breath_level(g, PERIOD);
        assign w_rom[g] = LVL;
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_level <= w_rom[i_addr];
        end
    end

    assign o_level = r_level;

endmodule

// ===== rtl/status_led_effect_generator.sv =====
// Set-mode transaction: taken while idle, no result.
// Tick transaction: S_LEVEL, then three passes through one shared 26x26 multiplier,
// then S_SAT; the result is held valid in S_OUT, and the next transaction is taken
// the cycle after the result is taken.
// Reset (synchronous, active low): mode off, counters zero, duty_bits 8, brightness 256,
// invert 0, no result pending.
module status_led_effect_generator #(
    parameter int BREATH_PERIOD_MS = sleg_pkg::BREATH_PERIOD_MS_DEF,
    parameter int BLINK_HALF_MS    = sleg_pkg::BLINK_HALF_MS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    sleg_item_if.sink     i_item,
    sleg_result_if.source o_result,
    sleg_cfg_if.sink      i_cfg
);

    localparam int EW = $clog2(BREATH_PERIOD_MS);
    localparam int KW = $clog2(BREATH_PERIOD_MS / 2 + 1);
    localparam int CW = $clog2(BLINK_HALF_MS + 1);
    localparam int MW = sleg_pkg::MUL_W;
    localparam int DW = sleg_pkg::DUTY_W;
    localparam int QW = sleg_pkg::PROD_W - sleg_pkg::RECIP_SHIFT;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LEVEL,
        S_MUL_VB,
        S_MUL_M,
        S_MUL_R,
        S_SAT,
        S_OUT
    } t_state;

    t_state                          r_state;
    logic [sleg_pkg::DBITS_W-1:0]    r_duty_bits;
    logic [sleg_pkg::BRIGHT_W-1:0]   r_brightness;
    logic                            r_invert;
    sleg_pkg::t_mode                 r_mode;
    logic [EW-1:0]                   r_elapsed;
    logic [CW-1:0]                   r_blink_cnt;
    logic                            r_blink_dark;
    logic [sleg_pkg::LEVEL_W-1:0]    r_level;
    logic                            r_use_rom;
    logic [sleg_pkg::PROD_W-1:0]     r_prod;
    logic                            r_out_valid;
    logic [DW-1:0]                   r_red;
    logic [DW-1:0]                   r_green;
    logic [DW-1:0]                   r_blue;

    logic                            w_item_acc;
    logic                            w_cfg_acc;
    logic [EW:0]                     w_rest;
    logic [KW-1:0]                   w_fold;
    logic [sleg_pkg::LEVEL_W-1:0]    w_rom_level;
    logic [sleg_pkg::LEVEL_W-1:0]    w_level;
    logic [sleg_pkg::DBITS_W-1:0]    w_bits;
    logic [DW-1:0]                   w_full;
    logic [MW-1:0]                   w_mul_a;
    logic [MW-1:0]                   w_mul_b;
    logic [QW-1:0]                   w_quo;
    logic [DW-1:0]                   w_duty;
    logic [DW-1:0]                   w_red;
    logic [DW-1:0]                   w_green;
    logic [DW-1:0]                   w_blue;

    assign w_item_acc     = i_item.valid && i_item.ready;
    assign w_cfg_acc      = i_cfg.valid && i_cfg.ready;
    assign i_item.ready   = (r_state == S_IDLE);
    assign i_cfg.ready    = 1'b1;

    // Fold the phase onto the first half of the period
    assign w_rest = (EW + 1)'(BREATH_PERIOD_MS) - {1'b0, r_elapsed};
    assign w_fold = ({1'b0, r_elapsed} <= w_rest) ? KW'(r_elapsed) : KW'(w_rest);

    sleg_breath_rom #(
        .PERIOD (BREATH_PERIOD_MS)
    ) u_rom (
        .i_clk   (i_clk),
        .i_rd_en (r_state == S_LEVEL),
        .i_addr  (w_fold),
        .o_level (w_rom_level)
    );

    assign w_level = r_use_rom ? w_rom_level : r_level;

    always_comb begin
        if (r_duty_bits == '0) begin
            w_bits = 5'd1;
        end else if (r_duty_bits > 5'd16) begin
            w_bits = 5'd16;
        end else begin
            w_bits = r_duty_bits;
        end
    end

    assign w_full = DW'((17'd1 << w_bits) - 17'd1);

    // Shared multiplier: level*brightness, then *full scale, then reciprocal of 255
    always_comb begin
        case (r_state)
            S_MUL_VB: begin
                w_mul_a = MW'(w_level);
                w_mul_b = MW'(r_brightness);
            end
            S_MUL_M: begin
                w_mul_a = MW'(r_prod[16:0]);
                w_mul_b = MW'(w_full);
            end
            default: begin
                w_mul_a = MW'(r_prod[32:8]);
                w_mul_b = sleg_pkg::RECIP_255;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= {{MW{1'b0}}, w_mul_a} * {{MW{1'b0}}, w_mul_b};
    end

    assign w_quo  = r_prod[sleg_pkg::PROD_W-1:sleg_pkg::RECIP_SHIFT];
    assign w_duty = (w_quo > QW'(w_full)) ? w_full : w_quo[DW-1:0];

    always_comb begin
        w_red   = '0;
        w_green = '0;
        w_blue  = '0;
        case (r_mode)
            sleg_pkg::MODE_CONNECTED:   w_green = w_duty;
            sleg_pkg::MODE_SENDING,
            sleg_pkg::MODE_ARMING: begin
                w_red   = w_duty;
                w_green = w_duty;
            end
            sleg_pkg::MODE_ADVERTISING: w_blue = w_duty;
            sleg_pkg::MODE_RED:         w_red = w_duty;
            default: ;
        endcase
        if (r_invert) begin
            w_red   = w_full - w_red;
            w_green = w_full - w_green;
            w_blue  = w_full - w_blue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_duty_bits  <= sleg_pkg::DUTY_BITS_RST;
            r_brightness <= sleg_pkg::BRIGHTNESS_RST;
            r_invert     <= 1'b0;
            r_mode       <= sleg_pkg::MODE_OFF;
            r_elapsed    <= '0;
            r_blink_cnt  <= '0;
            r_blink_dark <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (w_cfg_acc) begin
                case (i_cfg.index)
                    sleg_pkg::REG_DUTY_BITS:  r_duty_bits  <= i_cfg.data[sleg_pkg::DBITS_W-1:0];
                    sleg_pkg::REG_BRIGHTNESS: r_brightness <= i_cfg.data[sleg_pkg::BRIGHT_W-1:0];
                    sleg_pkg::REG_INVERT:     r_invert     <= i_cfg.data[0];
                    default: ;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (w_item_acc) begin
                        if (i_item.opcode == sleg_pkg::OP_SET_MODE) begin
                            // Drop unknown modes without touching the phase
                            if (i_item.new_mode <= sleg_pkg::MODE_RED) begin
                                r_mode    <= sleg_pkg::t_mode'(i_item.new_mode);
                                r_elapsed <= '0;
                            end
                        end else begin
                            r_state <= S_LEVEL;
                        end
                    end
                end
                S_LEVEL: begin
                    case (r_mode)
                        sleg_pkg::MODE_CONNECTED: r_level <= sleg_pkg::LVL_CONNECTED;
                        sleg_pkg::MODE_SENDING:   r_level <= sleg_pkg::LVL_SENDING;
                        sleg_pkg::MODE_ARMING:
                            r_level <= r_blink_dark ? '0 : sleg_pkg::LVL_ARMING;
                        sleg_pkg::MODE_RED:       r_level <= sleg_pkg::LVL_RED;
                        default:                  r_level <= '0;
                    endcase
                    r_use_rom <= (r_mode == sleg_pkg::MODE_ADVERTISING);
                    // Advance both counters after this tick's levels are captured
                    if (r_elapsed == EW'(BREATH_PERIOD_MS - 1)) begin
                        r_elapsed <= '0;
                    end else begin
                        r_elapsed <= r_elapsed + 1'b1;
                    end
                    if (r_blink_cnt == CW'(BLINK_HALF_MS - 1)) begin
                        r_blink_cnt  <= '0;
                        r_blink_dark <= !r_blink_dark;
                    end else begin
                        r_blink_cnt <= r_blink_cnt + 1'b1;
                    end
                    r_state <= S_MUL_VB;
                end
                S_MUL_VB: r_state <= S_MUL_M;
                S_MUL_M:  r_state <= S_MUL_R;
                S_MUL_R:  r_state <= S_SAT;
                S_SAT: begin
                    r_red       <= w_red;
                    r_green     <= w_green;
                    r_blue      <= w_blue;
                    r_out_valid <= 1'b1;
                    r_state     <= S_OUT;
                end
                S_OUT: begin
                    if (o_result.ready) begin
                        r_out_valid <= 1'b0;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_result.valid      = r_out_valid;
    assign o_result.red_duty   = r_red;
    assign o_result.green_duty = r_green;
    assign o_result.blue_duty  = r_blue;

`ifndef SYNTHESIS
    a_set_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_item_acc && (i_item.opcode == sleg_pkg::OP_SET_MODE) |=> !o_result.valid)
        else $error("set-mode transaction produced a result");

    a_tick_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_item_acc && (i_item.opcode == sleg_pkg::OP_TICK) |=> (r_state == S_LEVEL))
        else $error("tick transaction did not start the sequencer");

    a_no_accept_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |-> !i_item.ready)
        else $error("input taken while a result is pending");

    a_duty_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |-> (o_result.red_duty <= w_full) && (o_result.green_duty <= w_full)
                           && (o_result.blue_duty <= w_full))
        else $error("duty above full scale");

    a_off_dark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid && (r_mode == sleg_pkg::MODE_OFF) && !r_invert |->
            (o_result.red_duty == '0) && (o_result.green_duty == '0)
            && (o_result.blue_duty == '0))
        else $error("off mode lit a channel");
`endif

endmodule
